// ===== src/strip_crossing_tile_core_defines.svh =====
// ---------------------------------------------------------------------------
// Strip crossing tile assertion macros
// Shared concurrent assertion forms for the strip crossing tile checkers.
// ---------------------------------------------------------------------------
`ifndef STRIP_CROSSING_TILE_CORE_DEFINES_SVH
`define STRIP_CROSSING_TILE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sct_pkg.sv =====
// ---------------------------------------------------------------------------
// Strip crossing tile package
// Shared widths, field types and the queue item layout.
// ---------------------------------------------------------------------------
package sct_pkg;

	localparam int INDEX_BITS_DEF = 8;
	localparam int GRID_BITS_DEF  = 7;
	localparam int LOC_BITS       = 5;
	localparam int REGION_BITS    = 2;
	// largest region difference, and so the extra grid bits a left shift needs
	localparam int GRID_SCALE_BITS = (1 << REGION_BITS) - 1;
	localparam int QUEUE_DEPTH    = 4;

	typedef logic [LOC_BITS-1:0]    loc_t;
	typedef logic [REGION_BITS-1:0] region_t;

	// one axis: ok, multiplied index, coarse index, divisor grid, multiplier grid
	function automatic int axis_width(int index_bits, int grid_bits);
		return 1 + 2 * index_bits + 2 * (grid_bits + GRID_SCALE_BITS);
	endfunction

	// item: location match, then X axis, then Y axis
	function automatic int item_width(int index_bits, int grid_bits);
		return 1 + 2 * axis_width(index_bits, grid_bits);
	endfunction

endpackage

// ===== src/sct_fifo.sv =====
// ---------------------------------------------------------------------------
// Strip crossing tile queue
// Small first-in first-out queue between the front and back parts.
// ---------------------------------------------------------------------------
module sct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== src/sct_front.sv =====
// ---------------------------------------------------------------------------
// Strip crossing tile front
// Rescale B's grid to A's region and sort each axis into fine and coarse.
// ---------------------------------------------------------------------------
module sct_front #(
	parameter int INDEX_BITS = 8,
	parameter int GRID_BITS  = 7
) (
	input  sct_pkg::loc_t    loc_a,
	input  sct_pkg::region_t region_a,
	input  logic [GRID_BITS-1:0]  grid_x_a,
	input  logic [GRID_BITS-1:0]  grid_y_a,
	input  logic [INDEX_BITS-1:0] index_x_a,
	input  logic [INDEX_BITS-1:0] index_y_a,
	input  sct_pkg::loc_t    loc_b,
	input  sct_pkg::region_t region_b,
	input  logic [GRID_BITS-1:0]  grid_x_b,
	input  logic [GRID_BITS-1:0]  grid_y_b,
	input  logic [INDEX_BITS-1:0] index_x_b,
	input  logic [INDEX_BITS-1:0] index_y_b,
	output logic [sct_pkg::item_width(INDEX_BITS, GRID_BITS)-1:0] item
);
	import sct_pkg::*;

	localparam int OG     = GRID_BITS + GRID_SCALE_BITS;
	localparam int AXIS_W = axis_width(INDEX_BITS, GRID_BITS);

	logic [OG-1:0]       gx_a;
	logic [OG-1:0]       gy_a;
	logic [OG-1:0]       gx_b;
	logic [OG-1:0]       gy_b;
	logic [AXIS_W-1:0]   axis_x;
	logic [AXIS_W-1:0]   axis_y;

	// The finer strip (larger grid) is the divisor; its index gets multiplied.
	function automatic logic [AXIS_W-1:0] classify(
		logic [OG-1:0] ga, logic [OG-1:0] gb,
		logic [INDEX_BITS-1:0] ia, logic [INDEX_BITS-1:0] ib
	);
		if (ga > gb) begin
			return {1'b1, ia, ib, ga, gb};
		end
		return {gb != '0, ib, ia, gb, ga};
	endfunction

	assign gx_a = OG'(grid_x_a);
	assign gy_a = OG'(grid_y_a);

	always_comb begin
		gx_b = OG'(grid_x_b);
		gy_b = OG'(grid_y_b);
		if (region_b > region_a) begin
			gx_b = OG'(grid_x_b) >> (region_b - region_a);
			gy_b = OG'(grid_y_b) >> (region_b - region_a);
		end else if (region_b < region_a) begin
			gx_b = OG'(grid_x_b) << (region_a - region_b);
			gy_b = OG'(grid_y_b) << (region_a - region_b);
		end
	end

	assign axis_x = classify(gx_a, gx_b, index_x_a, index_x_b);
	assign axis_y = classify(gy_a, gy_b, index_y_a, index_y_b);
	assign item   = {loc_a == loc_b, axis_x, axis_y};

endmodule

// ===== src/sct_back.sv =====
// ---------------------------------------------------------------------------
// Strip crossing tile back
// Check the scaled index window per axis and register the crossing result.
// ---------------------------------------------------------------------------
module sct_back #(
	parameter int INDEX_BITS = 8,
	parameter int GRID_BITS  = 7
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  logic [sct_pkg::item_width(INDEX_BITS, GRID_BITS)-1:0] q_item,
	output logic empty,
	input  logic pop,
	output logic hit_valid,
	output logic [GRID_BITS+sct_pkg::GRID_SCALE_BITS-1:0] cross_grid_x,
	output logic [GRID_BITS+sct_pkg::GRID_SCALE_BITS-1:0] cross_grid_y,
	output logic [INDEX_BITS-1:0] cross_x,
	output logic [INDEX_BITS-1:0] cross_y
);
	import sct_pkg::*;

	localparam int OG     = GRID_BITS + GRID_SCALE_BITS;
	localparam int AXIS_W = axis_width(INDEX_BITS, GRID_BITS);
	localparam int PW     = INDEX_BITS + OG;

	logic                  adv;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  loc_ok_s1;
	logic [1:0]            ok_s1;
	logic [1:0][PW-1:0]    prod_s1;
	logic [1:0][PW-1:0]    low_s1;
	logic [1:0][OG-1:0]    grid_s1;
	logic [1:0][INDEX_BITS-1:0] idx_s1;
	logic [1:0][AXIS_W-1:0] axis;
	logic [1:0]            hit;
	logic                  res_valid;

	// advance the whole back pipeline when the output register frees up
	assign adv   = !valid_s2 || pop;
	assign q_pop = adv && !q_empty;
	assign empty = !valid_s2;

	assign axis[1] = q_item[2*AXIS_W-1 -: AXIS_W];
	assign axis[0] = q_item[AXIS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !q_empty;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: fine index times coarse grid, and coarse index times fine grid
	always_ff @(posedge clk) begin
		if (q_pop) begin
			loc_ok_s1 <= q_item[2*AXIS_W];
			for (int a = 0; a < 2; a++) begin
				ok_s1[a]   <= axis[a][AXIS_W-1];
				idx_s1[a]  <= axis[a][AXIS_W-2 -: INDEX_BITS];
				grid_s1[a] <= axis[a][2*OG-1 -: OG];
				prod_s1[a] <= PW'(axis[a][AXIS_W-2 -: INDEX_BITS]) * PW'(axis[a][OG-1:0]);
				low_s1[a]  <= PW'(axis[a][AXIS_W-2-INDEX_BITS -: INDEX_BITS])
					* PW'(axis[a][2*OG-1 -: OG]);
			end
		end
	end

	// quotient equals the coarse index when low <= product < low + grid
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			hit[a] = ok_s1[a] && (low_s1[a] <= prod_s1[a])
				&& ({1'b0, prod_s1[a]} < ({1'b0, low_s1[a]} + (PW+1)'(grid_s1[a])));
		end
		res_valid = loc_ok_s1 && hit[1] && hit[0];
	end

	// stage 2: output register, zeroed when the strips do not cross
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			hit_valid    <= res_valid;
			cross_grid_x <= res_valid ? grid_s1[1] : '0;
			cross_grid_y <= res_valid ? grid_s1[0] : '0;
			cross_x      <= res_valid ? idx_s1[1] : '0;
			cross_y      <= res_valid ? idx_s1[0] : '0;
		end
	end

endmodule

// ===== src/strip_crossing_tile_core.sv =====
// ---------------------------------------------------------------------------
// Strip crossing tile core
// Path: a strip pair goes from the combinational front into the middle queue,
//   then the stage 1 multiply registers, then the output register.
// Throughput: one strip pair per cycle while the output register is popped or empty.
// Reset: arst_n clears all queue pointers and valid flags; no clearing pass.
// ---------------------------------------------------------------------------
module strip_crossing_tile_core #(
	parameter int INDEX_BITS = sct_pkg::INDEX_BITS_DEF,
	parameter int GRID_BITS  = sct_pkg::GRID_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input queue side
	input  logic push,
	output logic full,
	input  sct_pkg::loc_t    loc_a,
	input  sct_pkg::region_t region_a,
	input  logic [GRID_BITS-1:0]  grid_x_a,
	input  logic [GRID_BITS-1:0]  grid_y_a,
	input  logic [INDEX_BITS-1:0] index_x_a,
	input  logic [INDEX_BITS-1:0] index_y_a,
	input  sct_pkg::loc_t    loc_b,
	input  sct_pkg::region_t region_b,
	input  logic [GRID_BITS-1:0]  grid_x_b,
	input  logic [GRID_BITS-1:0]  grid_y_b,
	input  logic [INDEX_BITS-1:0] index_x_b,
	input  logic [INDEX_BITS-1:0] index_y_b,
	// result queue side
	output logic empty,
	input  logic pop,
	output logic hit_valid,
	output logic [GRID_BITS+sct_pkg::GRID_SCALE_BITS-1:0] cross_grid_x,
	output logic [GRID_BITS+sct_pkg::GRID_SCALE_BITS-1:0] cross_grid_y,
	output logic [INDEX_BITS-1:0] cross_x,
	output logic [INDEX_BITS-1:0] cross_y
);
	import sct_pkg::*;

	localparam int ITEM_W = item_width(INDEX_BITS, GRID_BITS);

	// classified beat entering and leaving the middle queue
	logic [ITEM_W-1:0] front_item;
	logic [ITEM_W-1:0] back_item;
	logic              mid_empty;
	logic              mid_pop;

	// Front: rescale B to A's region, pick the finer strip per axis.
	// Purely combinational, so a beat is accepted whenever the queue has room.
	sct_front #(
		.INDEX_BITS(INDEX_BITS),
		.GRID_BITS (GRID_BITS)
	) u_front (
		.loc_a    (loc_a),
		.region_a (region_a),
		.grid_x_a (grid_x_a),
		.grid_y_a (grid_y_a),
		.index_x_a(index_x_a),
		.index_y_a(index_y_a),
		.loc_b    (loc_b),
		.region_b (region_b),
		.grid_x_b (grid_x_b),
		.grid_y_b (grid_y_b),
		.index_x_b(index_x_b),
		.index_y_b(index_y_b),
		.item     (front_item)
	);

	// Middle queue: absorb output stalls so the front keeps taking beats.
	sct_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (front_item),
		.pop   (mid_pop),
		.empty (mid_empty),
		.rdata (back_item)
	);

	// Back: multiply, then check the integer quotient window and hold the
	// result in the output register until it is popped.
	sct_back #(
		.INDEX_BITS(INDEX_BITS),
		.GRID_BITS (GRID_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (mid_empty),
		.q_pop       (mid_pop),
		.q_item      (back_item),
		.empty       (empty),
		.pop         (pop),
		.hit_valid   (hit_valid),
		.cross_grid_x(cross_grid_x),
		.cross_grid_y(cross_grid_y),
		.cross_x     (cross_x),
		.cross_y     (cross_y)
	);

endmodule

// ===== src/strip_crossing_tile_core_checker.sv =====
// ---------------------------------------------------------------------------
// Strip crossing tile checker
// Port-level properties of the result side, bound to the core.
// ---------------------------------------------------------------------------
`include "strip_crossing_tile_core_defines.svh"

module strip_crossing_tile_core_checker #(
	parameter int INDEX_BITS = sct_pkg::INDEX_BITS_DEF,
	parameter int GRID_BITS  = sct_pkg::GRID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic hit_valid,
	input logic [GRID_BITS+sct_pkg::GRID_SCALE_BITS-1:0] cross_grid_x,
	input logic [GRID_BITS+sct_pkg::GRID_SCALE_BITS-1:0] cross_grid_y,
	input logic [INDEX_BITS-1:0] cross_x,
	input logic [INDEX_BITS-1:0] cross_y
);

	// a miss carries all-zero fields
	`SCT_ASSERT_IMP(a_miss_zero, clk, arst_n, !empty && !hit_valid, cross_grid_x == '0 && cross_grid_y == '0 && cross_x == '0 && cross_y == '0, "miss with nonzero fields")

	// a hit always reports a nonzero grid in both axes
	`SCT_ASSERT_IMP(a_hit_grid, clk, arst_n, !empty && hit_valid, cross_grid_x != '0 && cross_grid_y != '0, "hit with zero grid")

	// a result not taken stays put
	`SCT_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(hit_valid) && $stable(cross_x) && $stable(cross_y), "result changed while stalled")

endmodule

bind strip_crossing_tile_core strip_crossing_tile_core_checker #(
	.INDEX_BITS(INDEX_BITS),
	.GRID_BITS (GRID_BITS)
) u_checker (.*);
